/* design/prt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants for the parallel record transmitter.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int PINS_MAX  = 4;
    localparam int NPIN_W    = 3;
    localparam int PIN_IDX_W = 2;

    typedef enum logic [2:0] {
        CMD_OPEN  = 3'd0,
        CMD_CLOSE = 3'd1,
        CMD_START = 3'd2,
        CMD_BYTE  = 3'd3,
        CMD_POLL  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_CONFIG      = 3'd2,
        ST_BUSY        = 3'd3,
        ST_NOT_OWNED   = 3'd4,
        ST_ADMIT_TO    = 3'd5,
        ST_COMPLETE_TO = 3'd6,
        ST_PENDING     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_CTRL  = 2'd1,
        KIND_DATA  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ADMIT    = 2'd1,
        PH_SEND     = 2'd2,
        PH_COMPLETE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_MAX_REC  = 2'd0,
        CFG_ADMIT_TO = 2'd1,
        CFG_CMPL_TO  = 2'd2,
        CFG_STALL    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] length;
        logic [7:0]  data;
        logic        ready_n;
        logic [7:0]  tick_step;
    } item_t;

    typedef struct packed {
        logic [15:0] max_record_bytes;
        logic [15:0] admission_timeout;
        logic [15:0] completion_timeout;
        logic [23:0] stall_poll_limit;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic       valid_n;
        logic       clock_level;
        logic [7:0] data;
    } pin_t;

    typedef struct packed {
        status_t     status;
        status_t     first_fault;
        logic        busy;
        logic [31:0] records;
        logic [31:0] bytes;
    } reply_t;

    typedef struct packed {
        pin_t [PINS_MAX-1:0] pins;
        logic [NPIN_W-1:0]   npins;
        reply_t              reply;
    } step_t;

    localparam pin_t PIN_IDLE   = '{kind: KIND_CTRL, valid_n: 1'b1, clock_level: 1'b1,
                                    data: 8'd0};
    localparam pin_t PIN_SELECT = '{kind: KIND_CTRL, valid_n: 1'b0, clock_level: 1'b1,
                                    data: 8'd0};
    localparam pin_t PIN_CLK_LO = '{kind: KIND_CTRL, valid_n: 1'b0, clock_level: 1'b0,
                                    data: 8'd0};

endpackage
`default_nettype wire

/* design/prt_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prt_cfg
// Configuration registers and their validity check.
// ----------------------------------------------------------------------------
module prt_cfg
    import prt_pkg::*;
#(
    parameter int MAX_RECORD_LIMIT = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        busy,
    output cfg_t             cfg,
    output logic             cfg_ok
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    // writes are dropped while a stream runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_record_bytes   <= 16'd256;
            cfg_reg.admission_timeout  <= 16'd100;
            cfg_reg.completion_timeout <= 16'd100;
            cfg_reg.stall_poll_limit   <= 24'd1000;
        end
        else if (cfg_valid && !busy)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_REC:  cfg_reg.max_record_bytes   <= cfg_data[15:0];
                CFG_ADMIT_TO: cfg_reg.admission_timeout  <= cfg_data[15:0];
                CFG_CMPL_TO:  cfg_reg.completion_timeout <= cfg_data[15:0];
                CFG_STALL:    cfg_reg.stall_poll_limit   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    assign cfg_ok = (cfg_reg.max_record_bytes != 16'd0)
                 && (cfg_reg.max_record_bytes <= 16'(MAX_RECORD_LIMIT))
                 && (cfg_reg.admission_timeout != 16'd0)
                 && (cfg_reg.completion_timeout != 16'd0)
                 && (cfg_reg.stall_poll_limit != 24'd0);

endmodule
`default_nettype wire

/* design/prt_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prt_engine
// Input register, transmitter state and the single-pass step logic that
// turns one command into its pin writes and status reply.
// ----------------------------------------------------------------------------
module prt_engine
    import prt_pkg::*;
#(
    parameter int MAX_RECORD_LIMIT = 256
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    input  wire logic  cfg_ok,
    input  wire logic  can_load,
    output logic       load,
    output step_t      step,
    output logic       busy
);

    localparam int FW = $clog2(MAX_RECORD_LIMIT + 1);

    item_t          item_reg;
    logic           item_valid_reg;

    phase_t         phase_reg,     phase_next;
    logic           epoch_reg,     epoch_next;
    logic           busy_reg,      busy_next;
    status_t        fault_reg,     fault_next;
    logic [15:0]    remain_reg,    remain_next;
    logic [FW-1:0]  fill_reg,      fill_next;
    logic [16:0]    elapsed_reg,   elapsed_next;
    logic [23:0]    stalled_reg,   stalled_next;
    logic [31:0]    records_reg,   records_next;
    logic [31:0]    bytes_reg,     bytes_next;

    logic [15:0]    rec_len;
    logic [FW-1:0]  fill_inc;
    logic [15:0]    remain_after;
    logic [16:0]    elapsed_sum;
    logic [23:0]    stalled_inc;
    logic [15:0]    wait_limit;
    logic           admit;

    assign load     = item_valid_reg && can_load;
    assign in_ready = !item_valid_reg || can_load;
    assign busy     = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item;
        end
    end

    assign rec_len      = (remain_reg < cfg.max_record_bytes) ? remain_reg
                                                             : cfg.max_record_bytes;
    assign fill_inc     = fill_reg + 1'b1;
    assign remain_after = remain_reg - rec_len;
    assign elapsed_sum  = elapsed_reg + 17'(item_reg.tick_step);
    assign stalled_inc  = stalled_reg + 24'd1;
    assign admit        = (phase_reg == PH_ADMIT);
    assign wait_limit   = admit ? cfg.admission_timeout : cfg.completion_timeout;

    always_comb
    begin
        logic [NPIN_W-1:0] n;
        status_t           st;
        logic              start_rec;
        logic              finish;

        phase_next   = phase_reg;
        epoch_next   = epoch_reg;
        busy_next    = busy_reg;
        fault_next   = fault_reg;
        remain_next  = remain_reg;
        fill_next    = fill_reg;
        elapsed_next = elapsed_reg;
        stalled_next = stalled_reg;
        records_next = records_reg;
        bytes_next   = bytes_reg;
        step.pins    = '{default: PIN_IDLE};
        n            = '0;
        st           = ST_OK;
        start_rec    = 1'b0;
        finish       = 1'b0;

        case (cmd_t'(item_reg.cmd))
            CMD_OPEN, CMD_CLOSE:
            begin
                if (!cfg_ok)
                begin
                    st = ST_CONFIG;
                end
                else if (busy_reg)
                begin
                    st = ST_BUSY;
                end
                else
                begin
                    if (item_reg.cmd == CMD_OPEN)
                    begin
                        fault_next = ST_OK;
                        epoch_next = 1'b1;
                    end
                    else
                    begin
                        epoch_next = 1'b0;
                    end
                    step.pins[n[PIN_IDX_W-1:0]] = PIN_IDLE;
                    n  = n + 1'b1;
                    st = ST_OK;
                end
            end
            CMD_START:
            begin
                if (!cfg_ok)
                begin
                    st = ST_CONFIG;
                end
                else if (!epoch_reg)
                begin
                    if (fault_reg == ST_OK)
                    begin
                        fault_next = ST_NOT_OWNED;
                    end
                    st = ST_NOT_OWNED;
                end
                else if (busy_reg)
                begin
                    st = ST_BUSY;
                end
                else if (fault_reg != ST_OK)
                begin
                    st = fault_reg;
                end
                else if (item_reg.length == 16'd0)
                begin
                    st = ST_OK;
                end
                else
                begin
                    busy_next   = 1'b1;
                    remain_next = item_reg.length;
                    start_rec   = 1'b1;
                    st          = ST_PENDING;
                end
            end
            CMD_BYTE:
            begin
                if (phase_reg != PH_SEND)
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    step.pins[0] = '{kind: KIND_DATA, valid_n: 1'b0, clock_level: 1'b0,
                                     data: item_reg.data};
                    step.pins[1] = PIN_CLK_LO;
                    step.pins[2] = PIN_SELECT;
                    n         = NPIN_W'(3);
                    fill_next = fill_inc;
                    if (16'(fill_inc) >= rec_len)
                    begin
                        step.pins[3] = PIN_IDLE;
                        n            = NPIN_W'(4);
                        phase_next   = PH_COMPLETE;
                        elapsed_next = '0;
                        stalled_next = '0;
                    end
                    st = ST_PENDING;
                end
            end
            CMD_POLL:
            begin
                if (phase_reg == PH_ADMIT || phase_reg == PH_COMPLETE)
                begin
                    // admission wants ready_n low, completion wants it high
                    if (item_reg.ready_n == !admit)
                    begin
                        if (admit)
                        begin
                            step.pins[0] = PIN_SELECT;
                            n          = NPIN_W'(1);
                            phase_next = PH_SEND;
                            fill_next  = '0;
                            st         = ST_PENDING;
                        end
                        else
                        begin
                            records_next = records_reg + 32'd1;
                            bytes_next   = bytes_reg + 32'(rec_len);
                            remain_next  = remain_after;
                            if (remain_after == 16'd0)
                            begin
                                finish = 1'b1;
                                st     = ST_OK;
                            end
                            else
                            begin
                                start_rec = 1'b1;
                                st        = ST_PENDING;
                            end
                        end
                    end
                    else
                    begin
                        elapsed_next = elapsed_sum;
                        st           = admit ? ST_ADMIT_TO : ST_COMPLETE_TO;
                        if (elapsed_sum >= 17'(wait_limit))
                        begin
                            finish = 1'b1;
                        end
                        else if (item_reg.tick_step != 8'd0)
                        begin
                            stalled_next = '0;
                            st           = ST_PENDING;
                        end
                        else
                        begin
                            stalled_next = stalled_inc;
                            if (stalled_inc >= cfg.stall_poll_limit)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                st = ST_PENDING;
                            end
                        end
                    end
                end
                else
                begin
                    st = (phase_reg == PH_SEND) ? ST_PENDING : ST_OK;
                end
            end
            default:
            begin
                st = ST_INVALID;
            end
        endcase

        if (start_rec)
        begin
            step.pins[n[PIN_IDX_W-1:0]] = PIN_IDLE;
            n            = n + 1'b1;
            phase_next   = PH_ADMIT;
            elapsed_next = '0;
            stalled_next = '0;
            fill_next    = '0;
        end

        if (finish)
        begin
            step.pins[n[PIN_IDX_W-1:0]] = PIN_IDLE;
            n          = n + 1'b1;
            busy_next  = 1'b0;
            phase_next = PH_IDLE;
            if (st != ST_OK && fault_reg == ST_OK)
            begin
                fault_next = st;
            end
        end

        step.npins             = n;
        step.reply.status      = st;
        step.reply.first_fault = cfg_ok ? fault_next : ST_CONFIG;
        step.reply.busy        = busy_next;
        step.reply.records     = records_next;
        step.reply.bytes       = bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            epoch_reg   <= 1'b0;
            busy_reg    <= 1'b0;
            fault_reg   <= ST_OK;
            remain_reg  <= '0;
            fill_reg    <= '0;
            elapsed_reg <= '0;
            stalled_reg <= '0;
            records_reg <= '0;
            bytes_reg   <= '0;
        end
        else if (load)
        begin
            phase_reg   <= phase_next;
            epoch_reg   <= epoch_next;
            busy_reg    <= busy_next;
            fault_reg   <= fault_next;
            remain_reg  <= remain_next;
            fill_reg    <= fill_next;
            elapsed_reg <= elapsed_next;
            stalled_reg <= stalled_next;
            records_reg <= records_next;
            bytes_reg   <= bytes_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (phase_reg != PH_IDLE))
        else $error("busy flag out of step with phase");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SEND |-> (16'(fill_reg) < rec_len))
        else $error("record fill reached record length while sending");

    a_remain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> remain_reg != 16'd0)
        else $error("stream busy with nothing left to send");

    a_stream_open: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> epoch_reg && fault_reg == ST_OK)
        else $error("stream started without ownership or with a latched fault");
`endif

endmodule
`default_nettype wire

/* design/prt_out_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prt_out_queue
// Holds the results of one step and hands them out one beat at a time:
// the pin writes in order, then the status reply marked last.
// ----------------------------------------------------------------------------
module prt_out_queue
    import prt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire step_t        step,
    output logic              can_load,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [87:0]       m_axis_tdata,   // valid_n, clock_level, data_out[7:0],
                                              // status[2:0], first_fault[2:0],
                                              // busy_flag, records_done[31:0],
                                              // bytes_done[31:0], zero pad
    output logic [1:0]        m_axis_tuser,   // kind[1:0]
    output logic              m_axis_tlast
);

    pin_t [PINS_MAX-1:0] pins_reg;
    logic [NPIN_W-1:0]   npins_reg;
    reply_t              reply_reg;
    logic [NPIN_W-1:0]   rd_reg;
    logic                full_reg;

    logic                at_reply;
    pin_t                pin_cur;

    assign at_reply = (rd_reg == npins_reg);
    assign can_load = !full_reg || (m_axis_tready && at_reply);
    assign pin_cur  = pins_reg[rd_reg[PIN_IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            rd_reg   <= '0;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
            rd_reg   <= '0;
        end
        else if (full_reg && m_axis_tready)
        begin
            if (at_reply)
            begin
                full_reg <= 1'b0;
            end
            else
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pins_reg  <= step.pins;
            npins_reg <= step.npins;
            reply_reg <= step.reply;
        end
    end

    assign m_axis_tvalid = full_reg;
    assign m_axis_tlast  = at_reply;

    always_comb
    begin
        if (at_reply)
        begin
            m_axis_tuser = KIND_REPLY;
            m_axis_tdata = {7'd0, reply_reg.bytes, reply_reg.records, reply_reg.busy,
                            reply_reg.first_fault, reply_reg.status, 8'd0, 1'b0, 1'b0};
        end
        else
        begin
            m_axis_tuser = pin_cur.kind;
            m_axis_tdata = {7'd0, 32'd0, 32'd0, 1'b0, 3'd0, 3'd0, pin_cur.data,
                            pin_cur.clock_level, pin_cur.valid_n};
        end
    end

`ifndef SYNTHESIS
    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> rd_reg <= npins_reg)
        else $error("read pointer past the stored pin writes");

    a_last_reply: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_REPLY)
        else $error("last beat is not a status reply");

    a_npins_bound: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> npins_reg <= NPIN_W'(PINS_MAX))
        else $error("more pin writes stored than slots");
`endif

endmodule
`default_nettype wire

/* design/parallel_record_transmitter_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// parallel_record_transmitter_core
// Command-driven transmitter for a parallel ready/valid/clock byte link,
// cutting write streams into records with admission and completion timeouts.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                    Beat
// s_axis   in   s_axis_tvalid/tready         one command (tuser = cmd)
// m_axis   out  m_axis_tvalid/tready         one pin write or reply (tuser = kind)
// cfg      in   cfg_valid/cfg_ready          one register write (always ready)
//
// A command taking k results (1 to 5) holds the output port until all have gone; a
// command with a single reply passes at one per cycle while m_axis_tready is high,
// a payload byte that ends a record takes 5 results. The queue drains one beat per
// cycle with m_axis_tready high. Input register and result queue are both registered.
// Reset is asynchronous and clears all control state; there is no clearing pass.
// With m_axis_tready low the queue holds and the input register still takes one beat.
// ----------------------------------------------------------------------------
module parallel_record_transmitter_core
    import prt_pkg::*;
#(
    parameter int MAX_RECORD_LIMIT = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // length[15:0], data[7:0], ready_n,
                                             // tick_step[7:0], zero pad
    input  wire logic [2:0]  s_axis_tuser,   // cmd[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // valid_n, clock_level, data_out[7:0],
                                             // status[2:0], first_fault[2:0],
                                             // busy_flag, records_done[31:0],
                                             // bytes_done[31:0], zero pad
    output logic [1:0]       m_axis_tuser,   // kind[1:0]
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    item_t item;
    cfg_t  cfg;
    logic  cfg_ok;
    logic  busy;
    logic  can_load;
    logic  load;
    step_t step;

    assign item.cmd       = s_axis_tuser;
    assign item.length    = s_axis_tdata[15:0];
    assign item.data      = s_axis_tdata[23:16];
    assign item.ready_n   = s_axis_tdata[24];
    assign item.tick_step = s_axis_tdata[32:25];

    prt_cfg #(
        .MAX_RECORD_LIMIT (MAX_RECORD_LIMIT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cfg       (cfg),
        .cfg_ok    (cfg_ok)
    );

    prt_engine #(
        .MAX_RECORD_LIMIT (MAX_RECORD_LIMIT)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .item     (item),
        .cfg      (cfg),
        .cfg_ok   (cfg_ok),
        .can_load (can_load),
        .load     (load),
        .step     (step),
        .busy     (busy)
    );

    prt_out_queue u_out_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .step          (step),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire
